### rtl/rfs_pkg.sv
// shared types and constants for the rom free space scanner
`timescale 1ns / 1ps
package rfs_pkg;

	localparam int ADDR_W  = 24;
	localparam int NEXT_W  = 25;
	localparam int COUNT_W = 17;
	localparam int BANK_W  = 15;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 25;

	localparam logic [1:0] STATUS_CONT     = 2'd0;
	localparam logic [1:0] STATUS_FOUND    = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

	localparam logic [IDX_W-1:0] REG_RUN_LENGTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_END_ADDRESS = 3'd1;
	localparam logic [IDX_W-1:0] REG_IMAGE_SIZE  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FREE_VALUE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_BANK_CROSS  = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOROM_MODE  = 3'd5;

	localparam logic [7:0] TAG_S = 8'h53;
	localparam logic [7:0] TAG_T = 8'h54;
	localparam logic [7:0] TAG_A = 8'h41;
	localparam logic [7:0] TAG_R = 8'h52;

	localparam logic [15:0] TAG_CHECK = 16'hFFFF;
	localparam logic [COUNT_W:0] BANK_SIZE = 18'h08000;

	// classified request passed from front to back
	typedef struct packed {
		logic                begin_req;
		logic                stop;
		logic                is_free;
		logic                tag_hit;
		logic                bank_skip;
		logic                need_one;
		logic [COUNT_W-1:0]  need;
		logic [NEXT_W-1:0]   addr_p1;
		logic [NEXT_W-1:0]   tag_next;
		logic [NEXT_W-1:0]   bank_next;
		logic [ADDR_W-1:0]   found_addr;
	} class_t;

endpackage

### rtl/rfs_if.sv
// channel interfaces for requests, results and register writes
`timescale 1ns / 1ps
interface rfs_item_if;
	logic        valid;
	logic        ready;
	logic        begin_req;
	logic [23:0] address;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;
	logic [7:0]  byte5;
	logic [7:0]  byte6;
	logic [7:0]  byte7;
	modport source (output valid, begin_req, address, byte0, byte1, byte2, byte3,
		byte4, byte5, byte6, byte7, input ready);
	modport sink (input valid, begin_req, address, byte0, byte1, byte2, byte3,
		byte4, byte5, byte6, byte7, output ready);
endinterface

interface rfs_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [24:0] next_address;
	logic [23:0] found_address;
	modport source (output valid, status, next_address, found_address, input ready);
	modport sink (input valid, status, next_address, found_address, output ready);
endinterface

interface rfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [24:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/rfs_front.sv
// front end: configuration registers and request classification
`timescale 1ns / 1ps
module rfs_front #(
	parameter int ADDR_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rfs_item_if.sink             item,
	rfs_cfg_if.sink              cfg,
	input  logic                 q_full,
	output logic                 push,
	output rfs_pkg::class_t      push_data
);
	import rfs_pkg::*;

	localparam int MaskW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] AddrMask = ADDR_W'((64'd1 << MaskW) - 64'd1);

	logic [COUNT_W-1:0] run_length_q;
	logic [NEXT_W-1:0]  end_address_q;
	logic [NEXT_W-1:0]  image_size_q;
	logic [7:0]         free_value_q;
	logic               bank_cross_q;
	logic               lorom_q;

	logic [ADDR_W-1:0]  addr;
	logic [COUNT_W-1:0] need;
	logic [15:0]        tag_len;
	logic [15:0]        tag_inv;
	logic               tag_in_image;
	logic               tag_chars;
	logic [COUNT_W:0]   bank_sum;

	// register writes, always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q  <= COUNT_W'(1);
			end_address_q <= NEXT_W'(25'h1000000);
			image_size_q  <= NEXT_W'(25'h1000000);
			free_value_q  <= 8'h00;
			bank_cross_q  <= 1'b0;
			lorom_q       <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RUN_LENGTH:  run_length_q  <= cfg.data[COUNT_W-1:0];
				REG_END_ADDRESS: end_address_q <= cfg.data[NEXT_W-1:0];
				REG_IMAGE_SIZE:  image_size_q  <= cfg.data[NEXT_W-1:0];
				REG_FREE_VALUE:  free_value_q  <= cfg.data[7:0];
				REG_BANK_CROSS:  bank_cross_q  <= cfg.data[0];
				REG_LOROM_MODE:  lorom_q       <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// accept while the queue has room
	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	// classify the request
	always_comb begin
		addr         = item.address & AddrMask;
		need         = (run_length_q == '0) ? COUNT_W'(1) : run_length_q;
		tag_len      = {item.byte5, item.byte4};
		tag_inv      = {item.byte7, item.byte6};
		tag_in_image = ({1'b0, addr} + NEXT_W'(8)) < image_size_q;
		tag_chars    = (item.byte0 == TAG_S) && (item.byte1 == TAG_T) &&
			(item.byte2 == TAG_A) && (item.byte3 == TAG_R);
		bank_sum     = (COUNT_W+1)'(addr[BANK_W-1:0]) + {1'b0, need};

		push_data.begin_req  = item.begin_req;
		push_data.stop       = !lorom_q || ({1'b0, addr} >= end_address_q);
		push_data.is_free    = (item.byte0 == free_value_q);
		push_data.tag_hit    = tag_in_image && tag_chars && ((tag_len ^ tag_inv) == TAG_CHECK);
		push_data.bank_skip  = !bank_cross_q && (bank_sum > BANK_SIZE);
		push_data.need_one   = (need == COUNT_W'(1));
		push_data.need       = need;
		push_data.addr_p1    = {1'b0, addr} + NEXT_W'(1);
		push_data.tag_next   = {1'b0, addr} + NEXT_W'(tag_len) + NEXT_W'(9);
		push_data.bank_next  = {(NEXT_W-BANK_W)'({1'b0, addr[ADDR_W-1:BANK_W]})
			+ (NEXT_W-BANK_W)'(1), {BANK_W{1'b0}}};
		push_data.found_addr = addr + ADDR_W'(1) - ADDR_W'(need);
	end

endmodule

### rtl/rfs_queue.sv
// two-entry queue between the classifier and the run tracker
`timescale 1ns / 1ps
module rfs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rfs_pkg::class_t  push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output rfs_pkg::class_t  pop_data
);
	import rfs_pkg::*;

	class_t      mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/rfs_back.sv
// back end: run counting and the registered result
`timescale 1ns / 1ps
module rfs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  rfs_pkg::class_t  pop_data,
	output logic             pop,
	rfs_result_if.source     result
);
	import rfs_pkg::*;

	logic [COUNT_W-1:0] run_count_q;
	logic               valid_q;
	logic [1:0]         status_q;
	logic [NEXT_W-1:0]  next_q;
	logic [ADDR_W-1:0]  found_q;

	logic [COUNT_W-1:0] rc;
	logic [COUNT_W-1:0] rc_inc;
	logic [COUNT_W-1:0] rc_new;
	logic [1:0]         status_d;
	logic [NEXT_W-1:0]  next_d;
	logic [ADDR_W-1:0]  found_d;

	assign pop = not_empty && (!valid_q || result.ready);

	assign result.valid         = valid_q;
	assign result.status        = status_q;
	assign result.next_address  = next_q;
	assign result.found_address = found_q;

	// next step of the open run
	always_comb begin
		rc       = pop_data.begin_req ? '0 : run_count_q;
		rc_inc   = rc + COUNT_W'(1);
		rc_new   = rc;
		status_d = STATUS_CONT;
		next_d   = pop_data.addr_p1;
		found_d  = '0;
		if (pop_data.stop) begin
			rc_new   = '0;
			status_d = STATUS_NOTFOUND;
			next_d   = '0;
		end else if (rc != '0) begin
			if (pop_data.is_free) begin
				if (rc_inc >= pop_data.need) begin
					rc_new   = '0;
					status_d = STATUS_FOUND;
					next_d   = '0;
					found_d  = pop_data.found_addr;
				end else begin
					rc_new = rc_inc;
				end
			end else begin
				rc_new = '0;
			end
		end else if (pop_data.tag_hit) begin
			next_d = pop_data.tag_next;
		end else if (pop_data.bank_skip) begin
			next_d = pop_data.bank_next;
		end else if (pop_data.is_free) begin
			if (pop_data.need_one) begin
				status_d = STATUS_FOUND;
				next_d   = '0;
				found_d  = pop_data.found_addr;
			end else begin
				rc_new = COUNT_W'(1);
			end
		end
	end

	// run count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				run_count_q <= rc_new;
				valid_q     <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status_d;
			next_q   <= next_d;
			found_q  <= found_d;
		end
	end

endmodule

### rtl/rom_free_space_scanner.sv
// Free space scanner for a ROM image with protection tag skipping.
// item channel: one request per address, carrying begin_req, the address and
//   the eight image bytes starting there; accepted when valid and ready meet.
// result channel: one result per request, in order: status (continue, found,
//   not found), next_address to fetch, found_address of a completed run.
// cfg channel: register writes by index (run_length, end_address, image_size,
//   free_value, allow_bank_cross, lorom_mode), always ready; the user must write
//   them only while idle, which the block itself does not enforce.
// A request enters the queue when it is accepted and loads the result register
//   when the back end pops it, which a stalled result receiver can delay.
// Throughput: one request per cycle while result.ready stays high; the run counter
//   in the back end updates once per popped request and the classifier needs no state.
// A stalled receiver holds the result register; the queue absorbs two more
//   requests before item.ready drops.
// Reset clears the run count, the queue and the result valid, and loads the
//   register defaults (run length one, full 16 MiB range, LoROM enabled).
`timescale 1ns / 1ps
module rom_free_space_scanner #(
	parameter int ADDR_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	rfs_item_if.sink     item,
	rfs_result_if.source result,
	rfs_cfg_if.sink      cfg
);
	import rfs_pkg::*;

	logic   q_full;
	logic   push;
	logic   pop;
	logic   not_empty;
	class_t push_data;
	class_t pop_data;

	// classifier
	rfs_front #(
		.ADDR_BITS (ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	rfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	// run tracker
	rfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.result    (result)
	);

endmodule
